FILE: hw/rtl/bfa_pkg.sv
// Shared types and constants of the best-fit bitmap allocator.
`default_nettype none
package bfa_pkg;
	localparam int POOL_DEPTH_DEF = 256;
	localparam int ADDR_LIMIT     = 256;
	localparam int CNT_W          = 9;
	localparam int ADDR_W         = 8;

	typedef enum logic [1:0] {
		ST_OK        = 2'd0,
		ST_NO_SPACE  = 2'd1,
		ST_BAD_ADDR  = 2'd2,
		ST_ZERO_SIZE = 2'd3
	} status_t;

	typedef enum logic [3:0] {
		S_CLEAR,
		S_IDLE,
		S_ACHK,
		S_SCAN,
		S_CLOSE,
		S_AEVAL,
		S_MARK,
		S_FRD,
		S_FCHK,
		S_UNMARK,
		S_DONE
	} state_t;

	typedef struct packed {
		logic    clr_step;
		logic    accept;
		logic    scan_init;
		logic    scan_step;
		logic    scan_close;
		logic    mark_init;
		logic    mark_step;
		logic    len_rd;
		logic    unmark_init;
		logic    unmark_step;
		logic    emit;
		status_t emit_status;
	} cmd_t;

	typedef struct packed {
		logic clr_last;
		logic in_valid;
		logic in_free;
		logic size_zero;
		logic over_limit;
		logic scan_done;
		logic found;
		logic addr_bad;
		logic len_zero;
		logic walk_last;
		logic out_full;
	} stat_t;
endpackage
`default_nettype wire

FILE: hw/rtl/best_fit_bitmap_allocator.sv
// Top level of the best-fit bitmap allocator.
// After reset the block clears its bitmap and run-length memories, one cell a cycle, over all
// min(POOL_DEPTH, 256) cells, and takes no transaction until done. An allocate checks the size,
// scans the usable cells of the bitmap through a single RAM read port, one cell a cycle, then
// marks the best-fitting run one cell a cycle. A free reads the run length stored at its address
// and then clears the run one cell a cycle. A zero-size or over-limit allocate and a free of an
// address beyond the bitmap finish in their check state, a free where no run starts finishes after
// the length read, and an allocate that finds no fitting run finishes after the full scan.
// One transaction is in work at a time; the result register frees the input side.
`default_nettype none
module best_fit_bitmap_allocator #(
	parameter int POOL_DEPTH = bfa_pkg::POOL_DEPTH_DEF
) (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire logic                       cfg_wen,
	input  wire logic [bfa_pkg::CNT_W-1:0]  cfg_wdata,
	input  wire logic                       in_valid,
	output logic                            in_stall,
	input  wire logic                       mode,
	input  wire logic [bfa_pkg::CNT_W-1:0]  alloc_size,
	input  wire logic [bfa_pkg::ADDR_W-1:0] free_address,
	output logic                            out_valid,
	input  wire logic                       out_stall,
	output logic [1:0]                      status,
	output logic [bfa_pkg::ADDR_W-1:0]      address,
	output logic [bfa_pkg::CNT_W-1:0]       freed_size
);
	bfa_pkg::cmd_t  cmd;
	bfa_pkg::stat_t stat;
	logic           idle;

	bfa_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.stat   (stat),
		.cmd    (cmd),
		.idle   (idle)
	);

	bfa_dp #(.POOL_DEPTH(POOL_DEPTH)) u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.stat         (stat),
		.cfg_wen      (cfg_wen),
		.cfg_wdata    (cfg_wdata),
		.in_valid     (in_valid),
		.mode         (mode),
		.alloc_size   (alloc_size),
		.free_address (free_address),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.status       (status),
		.address      (address),
		.freed_size   (freed_size)
	);

	assign in_stall = !idle;
endmodule
`default_nettype wire

FILE: hw/rtl/bfa_ram.sv
// Generic single-write, single-read RAM with registered read data.
`default_nettype none
module bfa_ram #(
	parameter int WIDTH = 1,
	parameter int DEPTH = 256
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic                     re,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end
endmodule
`default_nettype wire

FILE: hw/rtl/bfa_ctrl.sv
// Controller state machine of the best-fit bitmap allocator.
`default_nettype none
module bfa_ctrl (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire bfa_pkg::stat_t stat,
	output bfa_pkg::cmd_t       cmd,
	output logic                idle
);
	bfa_pkg::state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= bfa_pkg::S_CLEAR;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			bfa_pkg::S_CLEAR: if (stat.clr_last) state_d = bfa_pkg::S_IDLE;
			bfa_pkg::S_IDLE: begin
				if (stat.in_valid) begin
					state_d = stat.in_free ? bfa_pkg::S_FRD : bfa_pkg::S_ACHK;
				end
			end
			bfa_pkg::S_ACHK: begin
				if (stat.size_zero || stat.over_limit) begin
					if (!stat.out_full) state_d = bfa_pkg::S_IDLE;
				end else begin
					state_d = bfa_pkg::S_SCAN;
				end
			end
			bfa_pkg::S_SCAN: if (stat.scan_done) state_d = bfa_pkg::S_CLOSE;
			bfa_pkg::S_CLOSE: state_d = bfa_pkg::S_AEVAL;
			bfa_pkg::S_AEVAL: begin
				if (stat.found) begin
					state_d = bfa_pkg::S_MARK;
				end else if (!stat.out_full) begin
					state_d = bfa_pkg::S_IDLE;
				end
			end
			bfa_pkg::S_MARK: if (stat.walk_last) state_d = bfa_pkg::S_DONE;
			bfa_pkg::S_FRD: begin
				if (stat.addr_bad) begin
					if (!stat.out_full) state_d = bfa_pkg::S_IDLE;
				end else begin
					state_d = bfa_pkg::S_FCHK;
				end
			end
			bfa_pkg::S_FCHK: begin
				if (!stat.len_zero) begin
					state_d = bfa_pkg::S_UNMARK;
				end else if (!stat.out_full) begin
					state_d = bfa_pkg::S_IDLE;
				end
			end
			bfa_pkg::S_UNMARK: if (stat.walk_last) state_d = bfa_pkg::S_DONE;
			bfa_pkg::S_DONE: if (!stat.out_full) state_d = bfa_pkg::S_IDLE;
			default: state_d = bfa_pkg::S_CLEAR;
		endcase
	end

	always_comb begin
		cmd             = '0;
		cmd.emit_status = bfa_pkg::ST_OK;
		idle            = 1'b0;
		unique case (state_q)
			bfa_pkg::S_CLEAR: cmd.clr_step = 1'b1;
			bfa_pkg::S_IDLE: begin
				idle       = 1'b1;
				cmd.accept = stat.in_valid;
			end
			bfa_pkg::S_ACHK: begin
				if (stat.size_zero) begin
					cmd.emit        = !stat.out_full;
					cmd.emit_status = bfa_pkg::ST_ZERO_SIZE;
				end else if (stat.over_limit) begin
					cmd.emit        = !stat.out_full;
					cmd.emit_status = bfa_pkg::ST_NO_SPACE;
				end else begin
					cmd.scan_init = 1'b1;
				end
			end
			bfa_pkg::S_SCAN:  cmd.scan_step = 1'b1;
			bfa_pkg::S_CLOSE: cmd.scan_close = 1'b1;
			bfa_pkg::S_AEVAL: begin
				if (stat.found) begin
					cmd.mark_init = 1'b1;
				end else begin
					cmd.emit        = !stat.out_full;
					cmd.emit_status = bfa_pkg::ST_NO_SPACE;
				end
			end
			bfa_pkg::S_MARK: cmd.mark_step = 1'b1;
			bfa_pkg::S_FRD: begin
				if (stat.addr_bad) begin
					cmd.emit        = !stat.out_full;
					cmd.emit_status = bfa_pkg::ST_BAD_ADDR;
				end else begin
					cmd.len_rd = 1'b1;
				end
			end
			bfa_pkg::S_FCHK: begin
				if (!stat.len_zero) begin
					cmd.unmark_init = 1'b1;
				end else begin
					cmd.emit        = !stat.out_full;
					cmd.emit_status = bfa_pkg::ST_BAD_ADDR;
				end
			end
			bfa_pkg::S_UNMARK: cmd.unmark_step = 1'b1;
			bfa_pkg::S_DONE: begin
				cmd.emit        = !stat.out_full;
				cmd.emit_status = bfa_pkg::ST_OK;
			end
			default: ;
		endcase
	end
endmodule
`default_nettype wire

FILE: hw/rtl/bfa_dp.sv
// Datapath of the best-fit bitmap allocator: bitmap, run lengths, scan and output.
`default_nettype none
module bfa_dp #(
	parameter int POOL_DEPTH = bfa_pkg::POOL_DEPTH_DEF
) (
	input  wire logic                      clk,
	input  wire logic                      arst_n,
	input  wire bfa_pkg::cmd_t             cmd,
	output bfa_pkg::stat_t                 stat,
	input  wire logic                      cfg_wen,
	input  wire logic [bfa_pkg::CNT_W-1:0] cfg_wdata,
	input  wire logic                      in_valid,
	input  wire logic                      mode,
	input  wire logic [bfa_pkg::CNT_W-1:0] alloc_size,
	input  wire logic [bfa_pkg::ADDR_W-1:0] free_address,
	output logic                           out_valid,
	input  wire logic                      out_stall,
	output logic [1:0]                     status,
	output logic [bfa_pkg::ADDR_W-1:0]     address,
	output logic [bfa_pkg::CNT_W-1:0]      freed_size
);
	localparam int MAP_DEPTH = (POOL_DEPTH < bfa_pkg::ADDR_LIMIT) ? POOL_DEPTH
	                                                                : bfa_pkg::ADDR_LIMIT;
	localparam int AW = $clog2(MAP_DEPTH);
	localparam int CW = bfa_pkg::CNT_W;

	logic [CW-1:0] pool_q, used_q, size_q, limit_q;
	logic          mode_q;
	logic [7:0]    faddr_q;
	logic [AW-1:0] clr_idx_q;
	logic [AW:0]   rd_idx_q;
	logic          pend_s1;
	logic [AW-1:0] idx_s1;
	logic          in_run_q, found_q;
	logic [AW-1:0] cur_start_q, best_start_q;
	logic [CW-1:0] cur_len_q, best_len_q;
	logic [AW-1:0] walk_addr_q;
	logic [CW-1:0] walk_left_q, freed_q;
	logic          out_valid_q;
	logic [1:0]    status_q;
	logic [7:0]    addr_q;
	logic [CW-1:0] freed_out_q;

	logic          map_rd;
	logic [0:0]    map_q;
	logic          map_we;
	logic [AW-1:0] map_waddr;
	logic [0:0]    map_wdata;
	logic          len_we;
	logic [AW-1:0] len_waddr;
	logic [CW-1:0] len_wdata, len_q;
	logic          issue, fit, out_full;
	logic [CW-1:0] limit_d;
	logic [CW:0]   need;

	assign limit_d = (pool_q > CW'(MAP_DEPTH)) ? CW'(MAP_DEPTH) : pool_q;
	assign issue   = (CW'(rd_idx_q) < limit_q);
	assign map_rd  = cmd.scan_step && issue;
	assign fit     = in_run_q && (cur_len_q >= size_q) && (!found_q || cur_len_q < best_len_q);
	assign need    = {1'b0, used_q} + {1'b0, size_q};
	assign out_full = out_valid_q && out_stall;

	always_comb begin
		map_we    = cmd.clr_step || cmd.mark_step || cmd.unmark_step;
		map_waddr = cmd.clr_step ? clr_idx_q : walk_addr_q;
		map_wdata = cmd.mark_step ? 1'b1 : 1'b0;
		len_we    = cmd.clr_step || cmd.mark_init || cmd.unmark_init;
		len_waddr = clr_idx_q;
		len_wdata = '0;
		if (cmd.mark_init) begin
			len_waddr = best_start_q;
			len_wdata = size_q;
		end else if (cmd.unmark_init) begin
			len_waddr = faddr_q[AW-1:0];
		end
	end

	bfa_ram #(.WIDTH(1), .DEPTH(MAP_DEPTH)) u_map (
		.clk   (clk),
		.we    (map_we),
		.waddr (map_waddr),
		.wdata (map_wdata),
		.re    (map_rd),
		.raddr (rd_idx_q[AW-1:0]),
		.rdata (map_q)
	);

	bfa_ram #(.WIDTH(CW), .DEPTH(MAP_DEPTH)) u_len (
		.clk   (clk),
		.we    (len_we),
		.waddr (len_waddr),
		.wdata (len_wdata),
		.re    (cmd.len_rd),
		.raddr (faddr_q[AW-1:0]),
		.rdata (len_q)
	);

	always_comb begin
		stat.clr_last   = (clr_idx_q == AW'(MAP_DEPTH - 1));
		stat.in_valid   = in_valid;
		stat.in_free    = mode;
		stat.size_zero  = (size_q == '0);
		stat.over_limit = (need > {1'b0, limit_q});
		stat.scan_done  = !issue && !pend_s1;
		stat.found      = found_q;
		stat.addr_bad   = ({1'b0, faddr_q} >= 9'(MAP_DEPTH));
		stat.len_zero   = (len_q == '0);
		stat.walk_last  = (walk_left_q == CW'(1));
		stat.out_full   = out_full;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pool_q      <= CW'(256);
			used_q      <= '0;
			clr_idx_q   <= '0;
			pend_s1     <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_wen) pool_q <= cfg_wdata;
			if (cmd.clr_step) clr_idx_q <= clr_idx_q + AW'(1);
			if (cmd.scan_init) begin
				pend_s1 <= 1'b0;
			end else if (cmd.scan_step) begin
				pend_s1 <= issue;
			end
			if (cmd.mark_init) used_q <= need[CW-1:0];
			if (cmd.unmark_init) used_q <= (used_q >= len_q) ? used_q - len_q : '0;
			if (cmd.emit) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			mode_q  <= mode;
			size_q  <= alloc_size;
			faddr_q <= free_address;
			limit_q <= limit_d;
		end
		if (cmd.scan_init) begin
			rd_idx_q <= '0;
			in_run_q <= 1'b0;
			found_q  <= 1'b0;
		end else if (cmd.scan_step) begin
			if (issue) rd_idx_q <= rd_idx_q + (AW+1)'(1);
			idx_s1 <= rd_idx_q[AW-1:0];
			if (pend_s1) begin
				if (map_q == 1'b0) begin
					if (in_run_q) begin
						cur_len_q <= cur_len_q + CW'(1);
					end else begin
						in_run_q    <= 1'b1;
						cur_start_q <= idx_s1;
						cur_len_q   <= CW'(1);
					end
				end else begin
					in_run_q <= 1'b0;
					if (fit) begin
						found_q      <= 1'b1;
						best_start_q <= cur_start_q;
						best_len_q   <= cur_len_q;
					end
				end
			end
		end else if (cmd.scan_close) begin
			in_run_q <= 1'b0;
			if (fit) begin
				found_q      <= 1'b1;
				best_start_q <= cur_start_q;
				best_len_q   <= cur_len_q;
			end
		end
		if (cmd.mark_init) begin
			walk_addr_q <= best_start_q;
			walk_left_q <= size_q;
		end else if (cmd.unmark_init) begin
			walk_addr_q <= faddr_q[AW-1:0];
			walk_left_q <= len_q;
			freed_q     <= len_q;
		end else if (cmd.mark_step || cmd.unmark_step) begin
			walk_addr_q <= walk_addr_q + AW'(1);
			walk_left_q <= walk_left_q - CW'(1);
		end
		if (cmd.emit) begin
			status_q    <= cmd.emit_status;
			addr_q      <= (cmd.emit_status == bfa_pkg::ST_OK && !mode_q)
			               ? 8'(best_start_q) : '0;
			freed_out_q <= (cmd.emit_status == bfa_pkg::ST_OK && mode_q) ? freed_q : '0;
		end
	end

	assign out_valid  = out_valid_q;
	assign status     = status_q;
	assign address    = addr_q;
	assign freed_size = freed_out_q;
endmodule
`default_nettype wire
